// File: rtl/hbp_pkg.sv
// shared constants and types of the huffman bit packer
package hbp_pkg;

	localparam int SYM_W       = 8;
	localparam int LEN_IN_W    = 6;
	localparam int CODE_IN_W   = 32;
	localparam int FUNC_W      = 2;
	localparam int WORD_W      = 16;
	localparam int TABLE_DEPTH = 256;
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

	typedef struct packed {
		logic              not_empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

endpackage

// File: rtl/hbp_ram.sv
// generic single-write, single-read ram with registered read data
module hbp_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/hbp_front.sv
// front end: accepts items, writes and reads the code table, feeds the queue
module hbp_front #(
	parameter int MAX_CODE_LEN = 32,
	parameter int LW = $clog2(MAX_CODE_LEN + 1),
	parameter int CB = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             src_valid,
	output logic                             src_stall,
	input  logic [hbp_pkg::FUNC_W-1:0]       func,
	input  logic [hbp_pkg::SYM_W-1:0]        symbol,
	input  logic [hbp_pkg::LEN_IN_W-1:0]     code_len,
	input  logic [hbp_pkg::CODE_IN_W-1:0]    code_bits,
	input  hbp_pkg::q_stat_t                 q_stat,
	output logic                             push,
	output logic [LW+CB:0]                   push_data
);
	import hbp_pkg::*;

	logic                    accept;
	logic                    is_load;
	logic                    is_enc;
	logic                    is_flush;
	logic [LEN_IN_W-1:0]     len_sat;
	logic [CODE_IN_W-1:0]    code_mask;
	logic [LW+CB-1:0]        wr_entry;
	logic [LW+CB-1:0]        rd_entry;
	logic [QCNT_W:0]         fill;
	logic                    vld_s1;
	logic                    flush_s1;

	assign is_load  = (func == FUNC_LOAD);
	assign is_enc   = (func == FUNC_ENCODE);
	assign is_flush = (func == FUNC_FLUSH);

	// queue slots already taken plus the item in the table read stage
	assign fill      = {1'b0, q_stat.count} + {{QCNT_W{1'b0}}, vld_s1};
	assign src_stall = (fill >= (QCNT_W+1)'(QUEUE_DEPTH));
	assign accept    = src_valid && !src_stall;

	assign len_sat   = (code_len > LEN_IN_W'(MAX_CODE_LEN)) ? LEN_IN_W'(MAX_CODE_LEN) : code_len;
	assign code_mask = ~({CODE_IN_W{1'b1}} << len_sat);
	assign wr_entry  = {LW'(len_sat), CB'(code_bits & code_mask)};

	hbp_ram #(
		.WIDTH (LW + CB),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (accept && is_load),
		.waddr (symbol),
		.wdata (wr_entry),
		.re    (accept && is_enc),
		.raddr (symbol),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept && (is_enc || is_flush);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flush_s1 <= is_flush;
		end
	end

	// table data is ignored downstream for a flush
	assign push      = vld_s1;
	assign push_data = {flush_s1, rd_entry};

endmodule

// File: rtl/hbp_fifo.sv
// short queue between the table lookup and the bit merger
module hbp_fifo #(
	parameter int WIDTH = 39
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output hbp_pkg::q_stat_t stat
);
	import hbp_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign dout           = mem_q[rd_ptr_q];
	assign stat.not_empty = (cnt_q != '0);
	assign stat.count     = cnt_q;

endmodule

// File: rtl/hbp_back.sv
// back end: merges codes into the bit buffer and emits 16-bit words
module hbp_back #(
	parameter int MAX_CODE_LEN = 32,
	parameter int LW = $clog2(MAX_CODE_LEN + 1),
	parameter int CB = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hbp_pkg::q_stat_t              q_stat,
	input  logic [LW+CB:0]                head,
	output logic                          pop,
	output logic                          dst_valid,
	input  logic                          dst_stall,
	output logic [hbp_pkg::WORD_W-1:0]    out_word,
	output logic                          last,
	output logic                          from_flush
);
	import hbp_pkg::*;

	// up to 15 leftover bits plus the longest code
	localparam int BW  = WORD_W - 1 + MAX_CODE_LEN;
	localparam int CWR = $clog2(BW + 1);
	localparam int CW  = (CWR > 6) ? CWR : 6;

	logic              h_flush;
	logic [LW-1:0]     h_len;
	logic [CB-1:0]     h_code;
	logic [BW-1:0]     buf_q;
	logic [CW-1:0]     cnt_q;
	logic              vld_q;
	logic [WORD_W-1:0] word_q;
	logic              last_q;
	logic              flush_q;
	logic              out_free;
	logic              full_word;
	logic              below_two;
	logic              emit;
	logic              merge_ok;
	logic              flush_ok;
	logic              flush_emit;
	logic [CW-1:0]     cnt_base;
	logic [BW-1:0]     merged;
	logic [CW-1:0]     merged_cnt;
	logic [WORD_W-1:0] enc_word;
	logic [4:0]        pad_sh;
	logic [WORD_W-1:0] flush_word;

	assign {h_flush, h_len, h_code} = head;

	assign out_free  = !vld_q || !dst_stall;
	assign full_word = (cnt_q >= CW'(WORD_W));
	assign below_two = (cnt_q < CW'(2 * WORD_W));
	assign emit      = full_word && out_free;

	// a new code may enter once fewer than 16 bits stay after this cycle
	assign merge_ok   = q_stat.not_empty && !h_flush && (!full_word || (emit && below_two));
	assign flush_ok   = q_stat.not_empty && h_flush && !full_word && ((cnt_q == '0) || out_free);
	assign flush_emit = flush_ok && (cnt_q != '0);
	assign pop        = merge_ok || flush_ok;

	assign cnt_base   = emit ? cnt_q - CW'(WORD_W) : cnt_q;
	assign merged     = (buf_q << h_len) | BW'(h_code);
	assign merged_cnt = cnt_base + CW'(h_len);

	assign enc_word   = WORD_W'(buf_q >> (cnt_q - CW'(WORD_W)));
	assign pad_sh     = 5'd16 - {1'b0, cnt_q[3:0]};
	assign flush_word = WORD_W'(buf_q[WORD_W-1:0] << pad_sh);

	always_ff @(posedge clk) begin
		if (merge_ok) begin
			buf_q <= merged;
		end
		if (emit) begin
			word_q  <= enc_word;
			last_q  <= below_two;
			flush_q <= 1'b0;
		end else if (flush_emit) begin
			word_q  <= flush_word;
			last_q  <= 1'b1;
			flush_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (merge_ok) begin
				cnt_q <= merged_cnt;
			end else if (flush_ok) begin
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q - CW'(WORD_W);
			end
			if (emit || flush_emit) begin
				vld_q <= 1'b1;
			end else if (!dst_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign dst_valid  = vld_q;
	assign out_word   = word_q;
	assign last       = last_q;
	assign from_flush = flush_q;

endmodule

// File: rtl/huffman_bit_packer.sv
// Table-driven Huffman encoder that packs code bits into 16-bit words.
// The front end takes one item per cycle unless it stalls: a load writes a
// table entry, an encode reads it (one table read port, data registered),
// and encode and flush items then wait in a four-entry queue. The back end
// merges one code per cycle into its bit buffer while words do not back up,
// and puts out at most one word per cycle through an output register. With
// no output stall the sustained rate is one item per cycle while no item
// makes more than one word; one that makes more holds the back end until
// its last word goes out, and a flush right behind an item that made words
// waits while that item's last word goes out. An encode passes the table
// read, the queue and the bit buffer into the output register. The input
// stalls once the queued items plus the one in the lookup stage reach four.
module huffman_bit_packer #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  symbol,
	input  logic [5:0]  code_len,
	input  logic [31:0] code_bits,
	output logic        dst_valid,
	input  logic        dst_stall,
	output logic [15:0] out_word,
	output logic        last,
	output logic        from_flush
);
	import hbp_pkg::*;

	localparam int LW = $clog2(MAX_CODE_LEN + 1);
	localparam int CB = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

	q_stat_t         q_stat;
	logic            push;
	logic            pop;
	logic [LW+CB:0]  push_data;
	logic [LW+CB:0]  head;

	hbp_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.LW           (LW),
		.CB           (CB)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.func      (func),
		.symbol    (symbol),
		.code_len  (code_len),
		.code_bits (code_bits),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	hbp_fifo #(
		.WIDTH (LW + CB + 1)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.pop    (pop),
		.dout   (head),
		.stat   (q_stat)
	);

	hbp_back #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.LW           (LW),
		.CB           (CB)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head       (head),
		.pop        (pop),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.out_word   (out_word),
		.last       (last),
		.from_flush (from_flush)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.count == QCNT_W'(QUEUE_DEPTH)) |-> src_stall)
		else $error("input not stalled with queue full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.not_empty)
		else $error("pop from empty queue");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && from_flush) |-> last)
		else $error("flush word not marked last");

endmodule

// File: dv/huffman_bit_packer_tb.sv
// self-checking testbench for the huffman bit packer: table loads, encodes and flushes
module huffman_bit_packer_tb;
	import hbp_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;
	localparam int MAX_LEN     = 32;
	localparam int STUCK_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int HOLDOFF_LEN = 80;

	typedef struct {
		logic [FUNC_W-1:0]    func;
		logic [SYM_W-1:0]     symbol;
		logic [LEN_IN_W-1:0]  len;
		logic [CODE_IN_W-1:0] bits;
		bit                   drain_first;
		bit                   steady;
	} packer_item_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              last;
		logic              from_flush;
	} packed_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic [1:0]  func = FUNC_LOAD;
	logic [7:0]  symbol = '0;
	logic [5:0]  code_len = '0;
	logic [31:0] code_bits = '0;
	logic        dst_valid;
	logic        dst_stall = 1'b0;
	logic [15:0] out_word;
	logic        last;
	logic        from_flush;

	huffman_bit_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.func      (func),
		.symbol    (symbol),
		.code_len  (code_len),
		.code_bits (code_bits),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.out_word  (out_word),
		.last      (last),
		.from_flush(from_flush)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	packer_item_t pending_items[$];
	packed_word_t expected_words[$];
	int           errors = 0;
	int           idle_cycles = 0;
	int           items_added = 0;

	// generator bookkeeping: which table entries hold a code
	bit           loaded[TABLE_DEPTH];
	logic [7:0]   loaded_syms[$];

	// predictor state
	logic [5:0]   pred_len[TABLE_DEPTH];
	logic [31:0]  pred_code[TABLE_DEPTH];
	logic [15:0]  pred_acc = '0;
	int           pred_fill = 0;

	task automatic pack_item(input packer_item_t it);
		logic [5:0]   n;
		packed_word_t w;
		int           words;
		int           k;
		begin
			words = 0;
			case (it.func)
			FUNC_LOAD: begin
				n = (it.len > MAX_LEN) ? 6'(MAX_LEN) : it.len;
				pred_len[it.symbol] = n;
				pred_code[it.symbol] = (n >= 32) ? it.bits : it.bits & ((32'd1 << n) - 32'd1);
			end
			FUNC_ENCODE: begin
				for (k = int'(pred_len[it.symbol]) - 1; k >= 0; k--) begin
					pred_acc = {pred_acc[14:0], pred_code[it.symbol][k]};
					pred_fill++;
					if (pred_fill == 16) begin
						w.word = pred_acc;
						w.last = 1'b0;
						w.from_flush = 1'b0;
						expected_words.push_back(w);
						words++;
						pred_fill = 0;
					end
				end
				if (words > 0)
					expected_words[$].last = 1'b1;
			end
			FUNC_FLUSH: begin
				if (pred_fill != 0) begin
					w.word = pred_acc << (16 - pred_fill);
					w.last = 1'b1;
					w.from_flush = 1'b1;
					expected_words.push_back(w);
				end
				pred_acc = '0;
				pred_fill = 0;
			end
			default: ;
			endcase
		end
	endtask

	task automatic add_item(input logic [1:0] f, input logic [7:0] s, input logic [5:0] n,
			input logic [31:0] b);
		packer_item_t it;
		begin
			it.func = f;
			it.symbol = s;
			it.len = n;
			it.bits = b;
			// sender waits for the output to run dry before these items
			it.drain_first = (items_added == 120 || items_added == 280);
			it.steady = (items_added >= 160 && items_added < 240);
			if (f == FUNC_LOAD && !loaded[s]) begin
				loaded[s] = 1'b1;
				loaded_syms.push_back(s);
			end
			pending_items.push_back(it);
			items_added++;
		end
	endtask

	function automatic logic [5:0] pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 6'd0;
		else if (r < 3)
			return 6'($urandom_range(33, 63));
		else if (r < 5)
			return 6'($urandom_range(24, 32));
		else
			return 6'($urandom_range(1, 20));
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else begin
			if (src_valid && !src_stall) begin
				pack_item(pending_items[0]);
				void'(pending_items.pop_front());
			end
			if (!src_valid || !src_stall) begin
				if (pending_items.size() == 0) begin
					src_valid <= 1'b0;
				end else if (pending_items[0].drain_first && expected_words.size() != 0) begin
					src_valid <= 1'b0;
				end else if (!pending_items[0].steady && $urandom_range(0, 99) < 23) begin
					src_valid <= 1'b0;
				end else begin
					src_valid <= 1'b1;
					func <= pending_items[0].func;
					symbol <= pending_items[0].symbol;
					code_len <= pending_items[0].len;
					code_bits <= pending_items[0].bits;
				end
			end
		end
	end

	// monitor and receiver
	int words_seen = 0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		packed_word_t w;
		if (!arst_n) begin
			dst_stall <= 1'b0;
		end else begin
			if (dst_valid && !dst_stall) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word: actual %h last %b from_flush %b",
						$time, out_word, last, from_flush);
					errors++;
				end else begin
					w = expected_words.pop_front();
					if (out_word !== w.word) begin
						$display("%0t: out_word mismatch: expected %h actual %h",
							$time, w.word, out_word);
						errors++;
					end
					if (last !== w.last) begin
						$display("%0t: last mismatch: expected %b actual %b",
							$time, w.last, last);
						errors++;
					end
					if (from_flush !== w.from_flush) begin
						$display("%0t: from_flush mismatch: expected %b actual %b",
							$time, w.from_flush, from_flush);
						errors++;
					end
				end
			end
			if (!holdoff_done && words_seen >= 60) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_LEN;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				dst_stall <= 1'b1;
			end else if (words_seen >= 150 && words_seen < 260) begin
				dst_stall <= 1'b0;
			end else begin
				dst_stall <= ($urandom_range(0, 99) < 23);
			end
		end
	end

	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int          i;
		int          r;
		logic [7:0]  s;
		for (i = 0; i < TABLE_DEPTH; i++)
			loaded[i] = 1'b0;

		// directed: zero length, saturation, unused bits, word boundaries, flushes
		add_item(FUNC_LOAD, 8'h00, 6'd0, 32'hFFFF_FFFF);
		add_item(FUNC_LOAD, 8'hFF, 6'd63, 32'hFFFF_FFFF);
		add_item(FUNC_LOAD, 8'hAA, 6'd5, 32'hFFFF_FFE5);
		add_item(FUNC_LOAD, 8'h55, 6'd16, 32'h1234_A5C3);
		add_item(FUNC_LOAD, 8'h01, 6'd32, 32'h8000_0001);
		add_item(FUNC_LOAD, 8'h02, 6'd1, 32'h0000_0001);
		add_item(FUNC_FLUSH, 8'h00, 6'd0, 32'h0);
		add_item(FUNC_IGNORED, 8'hFF, 6'd63, 32'hFFFF_FFFF);
		add_item(FUNC_ENCODE, 8'h00, 6'd0, 32'h0);
		add_item(FUNC_ENCODE, 8'h55, 6'd0, 32'h0);
		add_item(FUNC_ENCODE, 8'h02, 6'd0, 32'h0);
		add_item(FUNC_ENCODE, 8'hFF, 6'd0, 32'h0);
		add_item(FUNC_ENCODE, 8'h01, 6'd0, 32'h0);
		add_item(FUNC_ENCODE, 8'hAA, 6'd0, 32'h0);
		add_item(FUNC_FLUSH, 8'hFF, 6'd63, 32'hFFFF_FFFF);
		add_item(FUNC_FLUSH, 8'h00, 6'd0, 32'h0);
		add_item(FUNC_ENCODE, 8'h55, 6'd63, 32'hFFFF_FFFF);
		add_item(FUNC_LOAD, 8'h80, 6'd40, 32'h0);
		add_item(FUNC_ENCODE, 8'h80, 6'd0, 32'h0);
		add_item(FUNC_IGNORED, 8'h00, 6'd0, 32'h0);
		add_item(FUNC_LOAD, 8'hAA, 6'd15, 32'h0000_7FFF);
		add_item(FUNC_ENCODE, 8'h02, 6'd0, 32'h0);
		add_item(FUNC_ENCODE, 8'hAA, 6'd0, 32'h0);
		add_item(FUNC_FLUSH, 8'h00, 6'd0, 32'h0);

		// random: fill part of the table, then encode runs with loads, flushes and noise
		for (i = 0; i < 24; i++)
			add_item(FUNC_LOAD, 8'($urandom_range(0, 255)), pick_len(), $urandom());
		while (items_added < 330) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				add_item(FUNC_LOAD, 8'($urandom_range(0, 255)), pick_len(), $urandom());
			end else if (r < 13) begin
				add_item(FUNC_IGNORED, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
					$urandom());
			end else if (r < 25) begin
				add_item(FUNC_FLUSH, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
					$urandom());
			end else begin
				s = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
				add_item(FUNC_ENCODE, s, 6'($urandom_range(0, 63)), $urandom());
			end
		end
		add_item(FUNC_FLUSH, 8'h00, 6'd0, 32'h0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending_items.size() != 0 || src_valid || expected_words.size() != 0)
				&& idle_cycles < STUCK_LIMIT)
			@(posedge clk);
		if (idle_cycles >= STUCK_LIMIT) begin
			$display("Some tests failed");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (errors == 0)
				$display("All tests passed");
			else
				$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/hbp_pkg.sv
rtl/hbp_ram.sv
rtl/hbp_front.sv
rtl/hbp_fifo.sv
rtl/hbp_back.sv
rtl/huffman_bit_packer.sv
dv/huffman_bit_packer_tb.sv
